// ===== hdl/rprt_pkg.sv =====
// Shared constants, codes and control types for the reserved port range table.
package rprt_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_ENTRIES);

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;    // input beat taken, latch request and clear scan
    logic step;    // examine one table entry
    logic finish;  // apply table update and load the result register
  } rprt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } rprt_sts_t;

endpackage

// ===== hdl/rprt_ctrl.sv =====
// Request sequencer: accept, scan the table, then hand off the result.
module rprt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rprt_pkg::rprt_sts_t sts_i,
  output rprt_pkg::rprt_cmd_t cmd_o
);
  import rprt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/rprt_dp.sv =====
// Table storage, one-entry-per-cycle scan logic and the result register.
module rprt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [1:0]                    action_i,
  input  logic [rprt_pkg::PORT_W-1:0]   range_low_i,
  input  logic [rprt_pkg::PORT_W-1:0]   range_high_i,
  input  logic [rprt_pkg::PORT_W-1:0]   query_port_i,
  input  rprt_pkg::rprt_cmd_t           cmd_i,
  output rprt_pkg::rprt_sts_t           sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic                          reserved_o
);
  import rprt_pkg::*;

  logic [PORT_W-1:0] entry_low_q  [MAX_ENTRIES];
  logic [PORT_W-1:0] entry_high_q [MAX_ENTRIES];
  logic              entry_removed_q [MAX_ENTRIES];
  logic [CNT_W-1:0]  count_q;
  logic              restrict_q;

  logic [1:0]        act_q;
  logic [PORT_W-1:0] lo_q, hi_q, port_q;
  logic              invalid_q;
  logic [CNT_W-1:0]  scan_q;
  logic              found_q;
  logic [IDX_W-1:0]  found_idx_q;
  logic              hit_q;

  logic              out_valid_q;
  logic [1:0]        status_q;
  logic              reserved_q;

  logic [IDX_W-1:0]  rd_idx;
  logic [PORT_W-1:0] rd_low, rd_high;
  logic              rd_removed;
  logic              same_range, covers_port;
  logic [1:0]        status_d;
  logic              do_append, do_mark;

  assign rd_idx      = scan_q[IDX_W-1:0];
  assign rd_low      = entry_low_q[rd_idx];
  assign rd_high     = entry_high_q[rd_idx];
  assign rd_removed  = entry_removed_q[rd_idx];
  assign same_range  = (rd_low == lo_q) && (rd_high == hi_q);
  assign covers_port = !rd_removed && (rd_low <= port_q) && (port_q <= rd_high);

  assign sts_o.scan_done = invalid_q || (scan_q == count_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // request latch and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.load) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      hit_q   <= 1'b0;
    end else if (cmd_i.step) begin
      scan_q <= scan_q + CNT_W'(1);
      if (same_range && !found_q) begin
        found_q <= 1'b1;
      end
      if (covers_port) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= action_i;
      lo_q      <= range_low_i;
      hi_q      <= range_high_i;
      port_q    <= query_port_i;
      invalid_q <= ((action_i != ACT_ADD) && (action_i != ACT_DEL) &&
                    (action_i != ACT_CHECK)) ||
                   ((action_i != ACT_CHECK) && (range_low_i > range_high_i));
    end
    if (cmd_i.step && same_range && !found_q) begin
      found_idx_q <= rd_idx;
    end
  end

  // outcome of the finished scan
  always_comb begin
    status_d  = ST_OK;
    do_append = 1'b0;
    do_mark   = 1'b0;
    if (invalid_q) begin
      status_d = ST_INVALID;
    end else if (act_q != ACT_CHECK) begin
      if (found_q) begin
        do_mark = 1'b1;
      end else if (act_q == ACT_DEL) begin
        status_d = ST_NOT_FOUND;
      end else if (count_q == FULL_COUNT) begin
        status_d = ST_FULL;
      end else begin
        do_append = 1'b1;
      end
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (do_mark) begin
        entry_removed_q[found_idx_q] <= (act_q == ACT_DEL);
      end else if (do_append) begin
        entry_low_q[count_q[IDX_W-1:0]]     <= lo_q;
        entry_high_q[count_q[IDX_W-1:0]]    <= hi_q;
        entry_removed_q[count_q[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      restrict_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        restrict_q <= cfg_wdata_i;
      end
      if (cmd_i.finish && do_append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q   <= status_d;
      reserved_q <= (act_q == ACT_CHECK) && restrict_q && hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign reserved_o  = reserved_q;

endmodule

// ===== hdl/reserved_port_range_table_unit.sv =====
// Reserved port range table: top level joining the sequencer and the table datapath.
// Each valid request beat (add, delete or check) walks the table one stored entry
// per clock through the single-entry compare in the scan loop; an invalid request
// skips the walk. The result sits in an output register, so a new request is taken
// while the previous result beat waits.
// Entries are appended and never removed; a delete only marks an entry and an add
// of the same range revives it. Checks answer 0 while restrict_enable is clear.
// Writing cfg_wdata_i with cfg_we_i high sets restrict_enable; write it only when idle.
module reserved_port_range_table_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  action_i,
  input  logic [rprt_pkg::PORT_W-1:0] range_low_i,
  input  logic [rprt_pkg::PORT_W-1:0] range_high_i,
  input  logic [rprt_pkg::PORT_W-1:0] query_port_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic                        reserved_o
);
  import rprt_pkg::*;

  rprt_cmd_t cmd;
  rprt_sts_t sts;

  rprt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rprt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (action_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .query_port_i (query_port_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .reserved_o   (reserved_o)
  );

endmodule

// ===== sim/port_table_checker.sv =====
// Checker for the reserved port range table: predicts each request's answer and compares.
module port_table_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [1:0]                  action_i,
  input  logic [rprt_pkg::PORT_W-1:0] range_low_i,
  input  logic [rprt_pkg::PORT_W-1:0] range_high_i,
  input  logic [rprt_pkg::PORT_W-1:0] query_port_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [1:0]                  status_i,
  input  logic                        reserved_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rprt_pkg::*;

  localparam int unsigned SHOW_LIMIT = 10;

  typedef struct packed {
    logic [1:0] status;
    logic       reserved;
  } port_answer_t;

  logic [PORT_W-1:0] tbl_lo  [MAX_ENTRIES];
  logic [PORT_W-1:0] tbl_hi  [MAX_ENTRIES];
  logic              tbl_off [MAX_ENTRIES];
  int                tbl_used;
  logic              screen_on;
  port_answer_t      answers_due[$];

  // Applies one request to the shadow table and returns the answer it must produce.
  function automatic port_answer_t apply_request(logic [1:0] act, logic [PORT_W-1:0] lo,
                                                 logic [PORT_W-1:0] hi,
                                                 logic [PORT_W-1:0] port);
    port_answer_t ans;
    int           slot;
    ans  = '{ST_OK, 1'b0};
    slot = -1;
    case (act)
      ACT_ADD, ACT_DEL: begin
        if (lo > hi) begin
          ans.status = ST_INVALID;
        end else begin
          for (int i = 0; i < tbl_used; i++)
            if (slot < 0 && tbl_lo[i] == lo && tbl_hi[i] == hi) slot = i;
          if (slot >= 0) begin
            // same range again: delete marks it, add revives it
            tbl_off[slot] = (act == ACT_DEL);
          end else if (act == ACT_DEL) begin
            ans.status = ST_NOT_FOUND;
          end else if (tbl_used >= MAX_ENTRIES) begin
            ans.status = ST_FULL;
          end else begin
            tbl_lo[tbl_used]  = lo;
            tbl_hi[tbl_used]  = hi;
            tbl_off[tbl_used] = 1'b0;
            tbl_used++;
          end
        end
      end
      ACT_CHECK: begin
        if (screen_on)
          for (int i = 0; i < tbl_used; i++)
            if (!tbl_off[i] && tbl_lo[i] <= port && port <= tbl_hi[i]) ans.reserved = 1'b1;
      end
      default: ans.status = ST_INVALID;
    endcase
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    port_answer_t got;
    port_answer_t want;
    if (!rst_ni) begin
      tbl_used     = 0;
      screen_on    = 1'b0;
      answers_due.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, reserved_i};
        if (answers_due.size() == 0) begin
          if (mismatches_o < SHOW_LIMIT)
            $display("%0t: result beat with nothing outstanding: status %0d reserved %0d",
                     $realtime, got.status, got.reserved);
          mismatches_o++;
        end else begin
          want = answers_due.pop_front();
          if (got.status !== want.status || got.reserved !== want.reserved) begin
            if (mismatches_o < SHOW_LIMIT)
              $display("%0t: mismatch: status exp %0d got %0d, reserved exp %0d got %0d",
                       $realtime, want.status, got.status, want.reserved, got.reserved);
            mismatches_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        answers_due.push_back(apply_request(action_i, range_low_i, range_high_i,
                                            query_port_i));
      if (cfg_we_i) screen_on = cfg_wdata_i;
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== sim/reserved_port_range_table_unit_tb.sv =====
// Testbench top for the reserved port range table: stimulus, idling and verdict.
module reserved_port_range_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rprt_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         POOL        = 20;
  localparam int         STALL_LIMIT = 2000;
  localparam int         DRAIN       = 25;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic              cfg_wdata_i  = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [1:0]        action_i     = ACT_CHECK;
  logic [PORT_W-1:0] range_low_i  = '0;
  logic [PORT_W-1:0] range_high_i = '0;
  logic [PORT_W-1:0] query_port_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b1;
  logic [1:0]        status_o;
  logic              reserved_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int          idle_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          calm        = 1'b0;

  logic [PORT_W-1:0] pool_lo[POOL];
  logic [PORT_W-1:0] pool_hi[POOL];

  reserved_port_range_table_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .range_low_i (range_low_i),
    .range_high_i(range_high_i),
    .query_port_i(query_port_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .reserved_o  (reserved_o)
  );

  port_table_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .action_i    (action_i),
    .range_low_i (range_low_i),
    .range_high_i(range_high_i),
    .query_port_i(query_port_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status_o),
    .reserved_i  (reserved_o),
    .mismatches_o(mismatches),
    .pending_o   (outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side back-pressure
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
        burst = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (burst) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // watchdog: cycles in which no beat moves on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Returns at the edge where the beat is taken, with valid still high.
  task automatic send_req(input logic [1:0] act, input logic [PORT_W-1:0] lo,
                          input logic [PORT_W-1:0] hi, input logic [PORT_W-1:0] port);
    int gap;
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    range_low_i  <= lo;
    range_high_i <= hi;
    query_port_i <= port;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drops valid and waits until every answer has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic set_restrict(input logic en);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= en;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_req();
    int                pick;
    int                k;
    logic [PORT_W-1:0] lo;
    logic [PORT_W-1:0] hi;
    logic [PORT_W-1:0] port;
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, POOL - 1);
    lo   = PORT_W'($urandom);
    hi   = PORT_W'($urandom);
    port = PORT_W'($urandom);
    if (pick < 30) begin
      send_req(ACT_ADD, pool_lo[k], pool_hi[k], port);
    end else if (pick < 52) begin
      send_req(ACT_DEL, pool_lo[k], pool_hi[k], port);
    end else if (pick < 85) begin
      // aim at the range edges most of the time
      case ($urandom_range(0, 4))
        0: port = pool_lo[k];
        1: port = pool_hi[k];
        2: port = pool_lo[k] - PORT_W'(1);
        3: port = pool_hi[k] + PORT_W'(1);
        default: ;
      endcase
      send_req(ACT_CHECK, lo, hi, port);
    end else if (pick < 93) begin
      // arbitrary range, reversed about half the time
      send_req($urandom_range(0, 1) ? ACT_ADD : ACT_DEL, lo, hi, port);
    end else if (pick < 97) begin
      send_req(ACT_CHECK, lo, hi, port);
    end else begin
      send_req(ACT_UNUSED, lo, hi, port);
    end
  endtask

  task automatic random_run(input int count);
    repeat (count) random_req();
  endtask

  initial begin
    int span;
    for (int i = 0; i < POOL; i++) begin
      pool_lo[i] = PORT_W'($urandom);
      span       = pool_lo[i] + $urandom_range(0, 3000);
      pool_hi[i] = (span > 16'hFFFF) ? 16'hFFFF : span[PORT_W-1:0];
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    tx_idle_pct = 20;
    rx_idle_pct = 10;
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd150);   // restrict off: never reserved
    set_restrict(1'b1);
    send_req(ACT_ADD, 16'd100, 16'd200, 16'hFFFF);
    send_req(ACT_ADD, 16'd300, 16'd200, 16'd0);   // reversed
    send_req(ACT_DEL, 16'd300, 16'd200, 16'd0);   // reversed
    send_req(ACT_DEL, 16'd5, 16'd6, 16'd0);       // absent
    send_req(ACT_CHECK, 16'hFFFF, 16'd0, 16'd100);
    send_req(ACT_CHECK, 16'd0, 16'hFFFF, 16'd200);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd99);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd201);
    send_req(ACT_ADD, 16'd100, 16'd200, 16'd0);   // already present
    send_req(ACT_DEL, 16'd100, 16'd200, 16'd0);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd150);
    send_req(ACT_DEL, 16'd100, 16'd200, 16'd0);   // already marked
    send_req(ACT_ADD, 16'd100, 16'd200, 16'd0);   // revive
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd150);
    send_req(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_req(ACT_ADD, 16'd0, 16'd0, 16'd0);
    send_req(ACT_ADD, 16'hFFFF, 16'hFFFF, 16'd0);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd0);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'hFFFF);
    send_req(ACT_ADD, 16'd0, 16'hFFFF, 16'd0);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd40000);
    send_req(ACT_DEL, 16'd0, 16'hFFFF, 16'd0);
    send_req(ACT_CHECK, 16'd0, 16'd0, 16'd40000);

    // random part; the table fills up early and stays full
    tx_idle_pct = 30;
    rx_idle_pct = 15;
    random_run(150);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(80);

    set_restrict(1'b0);
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    random_run(120);

    set_restrict(1'b1);
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    random_run(230);
    calm = 1'b1;
    random_run(100);

    drain_results();
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
